// ===== hw/rtl/serial_frame_receiver_crc16_core_defines.svh =====
// Assertion macros shared by the frame receiver checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SERIAL_FRAME_RECEIVER_CRC16_CORE_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_CORE_DEFINES_SVH

// Checked at every rising clock edge outside reset
`define SFRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included
`define SFRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/sfrc_pkg.sv =====
// Shared types, byte codes and CRC helper of the serial frame receiver.
// No dependencies; used by the controller, the datapath and the top level.
package sfrc_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  // Framing byte codes
  localparam logic [7:0] SOF_BYTE   = 8'h5a;
  localparam logic [7:0] ACK_BYTE   = 8'ha1;
  localparam logic [7:0] NAK_BYTE   = 8'ha2;
  localparam logic [7:0] TYPE_CMD   = 8'ha4;
  localparam logic [7:0] TYPE_DATA  = 8'ha5;
  localparam logic [7:0] TYPE_PING  = 8'ha6;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_MSB   = 16'h8000;

  localparam int PING_LEN = 10;

  // Result kinds
  localparam logic [1:0] KIND_XMIT  = 2'd0;
  localparam logic [1:0] KIND_PAY   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_CRC  = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_ACK0,
    S_ACK1,
    S_PING,
    S_CHECK,
    S_PAY,
    S_EMPTY,
    S_NAK0,
    S_NAK1
  } state_e;

  typedef enum logic [2:0] {
    SEL_ACK0,
    SEL_ACK1,
    SEL_NAK0,
    SEL_NAK1,
    SEL_PING,
    SEL_PAY,
    SEL_EMPTY
  } emit_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    logic      step;
    logic      ping_start;
    logic      ping_next;
    logic      pay_start;
    logic      pay_next;
    logic      emit;
    emit_sel_e sel;
    logic      last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ping;
    logic finish;
    logic crc_ok;
    logic len_zero;
    logic out_free;
    logic ping_last;
    logic pay_last;
  } sts_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // CRC state after the start byte
  localparam logic [15:0] CRC_AFTER_SOF = crc_byte(16'h0000, SOF_BYTE);

  // Fixed ping response
  function automatic logic [7:0] ping_byte(logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h5a;
      4'd1:    v = 8'ha7;
      4'd2:    v = 8'h00;
      4'd3:    v = 8'h02;
      4'd4:    v = 8'h01;
      4'd5:    v = 8'h50;
      4'd6:    v = 8'h00;
      4'd7:    v = 8'h00;
      4'd8:    v = 8'haa;
      4'd9:    v = 8'hea;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/sfrc_in_if.sv =====
// Input channel of the frame receiver: one link byte per item.
// No dependencies.
interface sfrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       expect_data;

  modport source (output valid, output rx_byte, output expect_data, input ready);
  modport sink   (input valid, input rx_byte, input expect_data, output ready);
endinterface

// ===== hw/rtl/sfrc_out_if.sv =====
// Output channel of the frame receiver: one result per item.
// No dependencies.
interface sfrc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic       crc_error;
  logic       last;

  modport source (output valid, output kind, output byte_value, output crc_error,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input crc_error,
                  input last, output ready);
endinterface

// ===== hw/rtl/sfrc_ctrl.sv =====
// Controller of the frame receiver: sequences byte handling and result emission.
// Depends on sfrc_pkg.
module sfrc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sfrc_pkg::sts_t sts_i,
  output sfrc_pkg::cmd_t cmd_o
);

  sfrc_pkg::state_e state_q, state_d;
  logic             ack_q, ack_d;

  // State and pending-ack registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfrc_pkg::S_IDLE;
      ack_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ack_q   <= ack_d;
    end
  end

  assign in_ready_o = (state_q == sfrc_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ack_d   = ack_q;
    cmd_o   = '0;
    cmd_o.sel = sfrc_pkg::SEL_ACK0;
    unique case (state_q)
      sfrc_pkg::S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = sfrc_pkg::S_EVAL;
        end
      end
      sfrc_pkg::S_EVAL: begin
        cmd_o.step = 1'b1;
        if (ack_q) begin
          ack_d   = 1'b0;
          state_d = sfrc_pkg::S_ACK0;
        end else if (sts_i.ping) begin
          cmd_o.ping_start = 1'b1;
          state_d = sfrc_pkg::S_PING;
        end else if (sts_i.finish) begin
          state_d = sfrc_pkg::S_CHECK;
        end else begin
          state_d = sfrc_pkg::S_IDLE;
        end
      end
      sfrc_pkg::S_CHECK: begin
        if (!sts_i.crc_ok) begin
          state_d = sfrc_pkg::S_NAK0;
        end else begin
          ack_d = 1'b1;
          if (sts_i.len_zero) begin
            state_d = sfrc_pkg::S_EMPTY;
          end else begin
            cmd_o.pay_start = 1'b1;
            state_d = sfrc_pkg::S_PAY;
          end
        end
      end
      sfrc_pkg::S_ACK0: begin
        cmd_o.sel  = sfrc_pkg::SEL_ACK0;
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) state_d = sfrc_pkg::S_ACK1;
      end
      sfrc_pkg::S_ACK1: begin
        cmd_o.sel  = sfrc_pkg::SEL_ACK1;
        cmd_o.last = 1'b1;
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) state_d = sfrc_pkg::S_IDLE;
      end
      sfrc_pkg::S_NAK0: begin
        cmd_o.sel  = sfrc_pkg::SEL_NAK0;
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) state_d = sfrc_pkg::S_NAK1;
      end
      sfrc_pkg::S_NAK1: begin
        cmd_o.sel  = sfrc_pkg::SEL_NAK1;
        cmd_o.last = 1'b1;
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) state_d = sfrc_pkg::S_IDLE;
      end
      sfrc_pkg::S_EMPTY: begin
        cmd_o.sel  = sfrc_pkg::SEL_EMPTY;
        cmd_o.last = 1'b1;
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) state_d = sfrc_pkg::S_IDLE;
      end
      sfrc_pkg::S_PING: begin
        cmd_o.sel  = sfrc_pkg::SEL_PING;
        cmd_o.last = sts_i.ping_last;
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) begin
          if (sts_i.ping_last) state_d = sfrc_pkg::S_IDLE;
          else cmd_o.ping_next = 1'b1;
        end
      end
      sfrc_pkg::S_PAY: begin
        cmd_o.sel  = sfrc_pkg::SEL_PAY;
        cmd_o.last = sts_i.pay_last;
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) begin
          if (sts_i.pay_last) state_d = sfrc_pkg::S_IDLE;
          else cmd_o.pay_next = 1'b1;
        end
      end
      default: begin
        state_d = sfrc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sfrc_dp.sv =====
// Datapath of the frame receiver: frame fields, CRC, payload memory, result register.
// Depends on sfrc_pkg.
module sfrc_dp #(
  parameter int MAX_PAYLOAD = sfrc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     rx_byte_i,
  input  logic           expect_data_i,
  input  sfrc_pkg::cmd_t cmd_i,
  output sfrc_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     byte_value_o,
  output logic           crc_error_o,
  output logic           last_o
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = LW + 1;

  // Frame state
  sfrc_pkg::phase_e phase_q, phase_d;
  logic [LW-1:0]    fc_q, fc_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [LW-1:0]    len_q, len_d;
  logic [15:0]      rcrc_q, rcrc_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       rx_q;
  logic             exp_q;
  logic [3:0]       ping_idx_q;
  logic [IW-1:0]    pidx_q, rd_addr;
  logic [7:0]       rd_q;
  logic [7:0]       mem [MAX_PAYLOAD];

  logic [7:0]  want;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [CW-1:0] fc_inc;
  logic        pay_wr;

  assign want     = exp_q ? sfrc_pkg::TYPE_DATA : sfrc_pkg::TYPE_CMD;
  assign crc_upd  = sfrc_pkg::crc_byte(crc_q, rx_q);
  assign len_full = {rx_q, len_lo_q};
  assign fc_inc   = CW'(fc_q) + CW'(1);
  assign pay_wr   = cmd_i.step && (phase_q == sfrc_pkg::PH_PAY);

  // Per-byte frame update
  always_comb begin
    phase_d  = phase_q;
    fc_d     = fc_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    rcrc_d   = rcrc_q;
    crc_d    = crc_q;
    unique case (phase_q)
      sfrc_pkg::PH_TYPE: begin
        if (rx_q == sfrc_pkg::TYPE_PING) begin
          phase_d = sfrc_pkg::PH_HUNT;
        end else if (rx_q == want) begin
          crc_d   = crc_upd;
          fc_d    = '0;
          len_d   = '0;
          phase_d = sfrc_pkg::PH_LEN;
        end else begin
          phase_d = sfrc_pkg::PH_HUNT;
        end
      end
      sfrc_pkg::PH_LEN: begin
        crc_d = crc_upd;
        if (!fc_q[0]) begin
          len_lo_d = rx_q;
          fc_d     = LW'(1);
        end else begin
          // clamp the received length to the buffer size
          if (len_full > 16'(MAX_PAYLOAD)) len_d = LW'(MAX_PAYLOAD);
          else len_d = len_full[LW-1:0];
          fc_d    = '0;
          phase_d = sfrc_pkg::PH_CRC;
        end
      end
      sfrc_pkg::PH_CRC: begin
        if (!fc_q[0]) begin
          rcrc_d[7:0] = rx_q;
          fc_d        = LW'(1);
        end else begin
          rcrc_d[15:8] = rx_q;
          fc_d         = '0;
          phase_d = (len_q == '0) ? sfrc_pkg::PH_HUNT : sfrc_pkg::PH_PAY;
        end
      end
      sfrc_pkg::PH_PAY: begin
        crc_d = crc_upd;
        if (fc_inc >= CW'(len_q)) begin
          fc_d    = '0;
          phase_d = sfrc_pkg::PH_HUNT;
        end else begin
          fc_d = fc_inc[LW-1:0];
        end
      end
      default: begin
        // hunting, and any unused code
        phase_d = sfrc_pkg::PH_HUNT;
        if (rx_q == sfrc_pkg::SOF_BYTE) begin
          crc_d   = sfrc_pkg::CRC_AFTER_SOF;
          phase_d = sfrc_pkg::PH_TYPE;
        end
      end
    endcase
  end

  // Frame registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sfrc_pkg::PH_HUNT;
      fc_q     <= '0;
      len_lo_q <= '0;
      len_q    <= '0;
      rcrc_q   <= '0;
      crc_q    <= '0;
    end else if (cmd_i.step) begin
      phase_q  <= phase_d;
      fc_q     <= fc_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      rcrc_q   <= rcrc_d;
      crc_q    <= crc_d;
    end
  end

  // Input byte capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rx_q  <= rx_byte_i;
      exp_q <= expect_data_i;
    end
  end

  // Emission counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_idx_q <= '0;
      pidx_q     <= '0;
    end else begin
      if (cmd_i.ping_start) ping_idx_q <= '0;
      else if (cmd_i.ping_next) ping_idx_q <= ping_idx_q + 4'd1;
      if (cmd_i.pay_start || cmd_i.pay_next) pidx_q <= rd_addr;
    end
  end

  // Payload memory, registered read that follows the emission index
  always_comb begin
    if (cmd_i.pay_start) rd_addr = '0;
    else if (cmd_i.pay_next) rd_addr = pidx_q + IW'(1);
    else rd_addr = pidx_q;
  end

  always_ff @(posedge clk_i) begin
    if (pay_wr) mem[fc_q[IW-1:0]] <= rx_q;
    rd_q <= mem[rd_addr];
  end

  // Status toward the controller
  assign sts_o.ping      = (phase_q == sfrc_pkg::PH_TYPE) && (rx_q == sfrc_pkg::TYPE_PING);
  assign sts_o.finish    = ((phase_q == sfrc_pkg::PH_CRC) && fc_q[0] && (len_q == '0)) ||
                           ((phase_q == sfrc_pkg::PH_PAY) && (fc_inc >= CW'(len_q)));
  assign sts_o.crc_ok    = (crc_q == rcrc_q);
  assign sts_o.len_zero  = (len_q == '0);
  assign sts_o.out_free  = !out_valid_o || out_ready_i;
  assign sts_o.ping_last = (ping_idx_q == 4'(sfrc_pkg::PING_LEN - 1));
  assign sts_o.pay_last  = ((CW'(pidx_q) + CW'(1)) == CW'(len_q));

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      last_o <= cmd_i.last;
      unique case (cmd_i.sel)
        sfrc_pkg::SEL_ACK0: begin
          kind_o <= sfrc_pkg::KIND_XMIT; byte_value_o <= sfrc_pkg::SOF_BYTE;
          crc_error_o <= 1'b0;
        end
        sfrc_pkg::SEL_ACK1: begin
          kind_o <= sfrc_pkg::KIND_XMIT; byte_value_o <= sfrc_pkg::ACK_BYTE;
          crc_error_o <= 1'b0;
        end
        sfrc_pkg::SEL_NAK0: begin
          kind_o <= sfrc_pkg::KIND_XMIT; byte_value_o <= sfrc_pkg::SOF_BYTE;
          crc_error_o <= 1'b1;
        end
        sfrc_pkg::SEL_NAK1: begin
          kind_o <= sfrc_pkg::KIND_XMIT; byte_value_o <= sfrc_pkg::NAK_BYTE;
          crc_error_o <= 1'b1;
        end
        sfrc_pkg::SEL_PING: begin
          kind_o <= sfrc_pkg::KIND_XMIT; byte_value_o <= sfrc_pkg::ping_byte(ping_idx_q);
          crc_error_o <= 1'b0;
        end
        sfrc_pkg::SEL_PAY: begin
          kind_o <= sfrc_pkg::KIND_PAY; byte_value_o <= rd_q;
          crc_error_o <= 1'b0;
        end
        default: begin
          kind_o <= sfrc_pkg::KIND_EMPTY; byte_value_o <= 8'h00;
          crc_error_o <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/serial_frame_receiver_crc16_core.sv =====
// Top level of the serial frame receiver with CRC-16 check.
// Depends on sfrc_pkg, sfrc_in_if, sfrc_out_if, sfrc_ctrl and sfrc_dp.
//
//   channel | dir | payload                                  | handshake
//   in_i    | in  | rx_byte[7:0], expect_data                | valid/ready
//   out_o   | out | kind[1:0], byte_value[7:0], crc_error, last | valid/ready
//
// One byte at a time: accept, update the frame state, then one result per
// cycle through the output register while the output is free (a CRC check
// state precedes the results of a completed frame). The payload memory read
// and the single output register set the pace. Reset is asynchronous, active
// low, and returns the receiver to hunting. A stalled output holds the block.
module serial_frame_receiver_crc16_core #(
  parameter int MAX_PAYLOAD = sfrc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfrc_in_if.sink    in_i,
  sfrc_out_if.source out_o
);

  sfrc_pkg::cmd_t cmd;
  sfrc_pkg::sts_t sts;
  logic           in_ready;

  assign in_i.ready = in_ready;

  sfrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfrc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (in_i.rx_byte),
    .expect_data_i (in_i.expect_data),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .kind_o        (out_o.kind),
    .byte_value_o  (out_o.byte_value),
    .crc_error_o   (out_o.crc_error),
    .last_o        (out_o.last)
  );

endmodule

// ===== hw/rtl/sfrc_checker.sv =====
// Port-level checks of the frame receiver, bound to the top level.
// Depends on sfrc_pkg and serial_frame_receiver_crc16_core_defines.svh.
`include "serial_frame_receiver_crc16_core_defines.svh"

module sfrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [7:0] byte_value_i,
  input logic       crc_error_i,
  input logic       last_i
);

  // a stalled result holds
  `SFRC_ASSERT(a_out_hold,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_value_i) &&
      $stable(kind_i) && $stable(last_i),
    "result changed while stalled")

  // no new byte is taken while a result sequence is still unfinished
  `SFRC_ASSERT(a_no_accept_mid_seq,
    out_valid_i && !last_i |-> !in_ready_i,
    "input ready in the middle of a result sequence")

  // NAK flag only on transmit bytes, empty-packet result carries zero
  `SFRC_ASSERT(a_kind_fields,
    out_valid_i && (kind_i != sfrc_pkg::KIND_XMIT) |-> !crc_error_i &&
      (kind_i <= sfrc_pkg::KIND_EMPTY) &&
      ((kind_i != sfrc_pkg::KIND_EMPTY) || (byte_value_i == 8'h00)),
    "bad field combination")

  // nothing is offered during reset
  `SFRC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind serial_frame_receiver_crc16_core sfrc_checker u_sfrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .byte_value_i (out_o.byte_value),
  .crc_error_i  (out_o.crc_error),
  .last_i       (out_o.last)
);
